// ===== hdl/gaq_pkg.sv =====
`default_nettype none

package gaq_pkg;

    localparam int unsigned DEPTH_DEF  = 64;
    localparam int unsigned GROUPS_DEF = 16;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned GROUP_W = 4;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned SVC_W   = 8;

    localparam logic [SVC_W-1:0] SVC_RESET = 8'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_SERVED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [GROUP_W-1:0] group;
        logic [TAG_W-1:0]   tag;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   served_tag;
        logic [GROUP_W-1:0] served_group;
        logic [CNT_W-1:0]   served_entry;
        logic [CNT_W-1:0]   exit_time;
        logic [CNT_W-1:0]   assigned_entry;
    } out_t;

    // contents of one queue position
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [GROUP_W-1:0] group;
        logic [CNT_W-1:0]   entry;
    } item_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic  do_push;
        logic  do_pop;
        logic  present;
        item_t new_item;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/gaq_cell.sv =====
`default_nettype none

module gaq_cell #(
    parameter int unsigned SEQ_W = 7
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gaq_pkg::ctrl_t      ctrl,
    input  wire logic [SEQ_W-1:0]    grp_seq,
    input  wire logic [SEQ_W-1:0]    new_seq,
    input  wire gaq_pkg::item_t      prev_item,
    input  wire logic                prev_valid,
    input  wire logic [SEQ_W-1:0]    prev_seq,
    input  wire logic                prev_match,
    input  wire gaq_pkg::item_t      next_item,
    input  wire logic                next_valid,
    input  wire logic [SEQ_W-1:0]    next_seq,
    output gaq_pkg::item_t           item,
    output logic                     valid,
    output logic [SEQ_W-1:0]         seq,
    output logic                     match
);

    gaq_pkg::item_t   item_reg,  item_next;
    logic             valid_reg, valid_next;
    logic [SEQ_W-1:0] seq_reg,   seq_next;
    logic [SEQ_W-1:0] diff;
    logic             after;
    logic             ins;

    assign match = valid_reg && (item_reg.group == ctrl.new_item.group);

    // runs are created in queue order, so a later run sequence means behind the group
    assign diff  = seq_reg - grp_seq;
    assign after = ctrl.present && valid_reg && (diff != '0) && !diff[SEQ_W-1];

    assign ins = ctrl.present ? (prev_match && !match) : (prev_valid && !valid_reg);

    always_comb begin
        item_next  = item_reg;
        valid_next = valid_reg;
        seq_next   = seq_reg;
        if (ctrl.do_pop) begin
            item_next  = next_item;
            valid_next = next_valid;
            seq_next   = next_seq;
        end else if (ctrl.do_push) begin
            if (ins) begin
                item_next  = ctrl.new_item;
                valid_next = 1'b1;
                seq_next   = new_seq;
            end else if (after || !valid_reg) begin
                item_next  = prev_item;
                valid_next = prev_valid;
                seq_next   = prev_seq;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
        seq_reg  <= seq_next;
    end

    assign item  = item_reg;
    assign valid = valid_reg;
    assign seq   = seq_reg;

endmodule

`default_nettype wire

// ===== hdl/gaq_chain.sv =====
`default_nettype none

module gaq_chain #(
    parameter int unsigned DEPTH = gaq_pkg::DEPTH_DEF,
    parameter int unsigned SEQ_W = $clog2(DEPTH) + 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire gaq_pkg::ctrl_t   ctrl,
    input  wire logic [SEQ_W-1:0] grp_seq,
    input  wire logic [SEQ_W-1:0] new_seq,
    output gaq_pkg::item_t        head_item,
    output logic                  head_valid,
    output gaq_pkg::item_t        second_item,
    output logic                  second_valid,
    output logic                  full
);

    gaq_pkg::item_t   c_item  [DEPTH];
    logic             c_valid [DEPTH];
    logic [SEQ_W-1:0] c_seq   [DEPTH];
    logic             c_match [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        gaq_pkg::item_t   p_item, n_item;
        logic             p_valid, p_match, n_valid;
        logic [SEQ_W-1:0] p_seq, n_seq;

        if (i == 0) begin : g_first
            // front boundary: valid so an empty queue fills here, never a group match
            assign p_item  = '0;
            assign p_valid = 1'b1;
            assign p_seq   = '0;
            assign p_match = 1'b0;
        end else begin : g_mid
            assign p_item  = c_item[i-1];
            assign p_valid = c_valid[i-1];
            assign p_seq   = c_seq[i-1];
            assign p_match = c_match[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign n_item  = '0;
            assign n_valid = 1'b0;
            assign n_seq   = '0;
        end else begin : g_inner
            assign n_item  = c_item[i+1];
            assign n_valid = c_valid[i+1];
            assign n_seq   = c_seq[i+1];
        end

        gaq_cell #(
            .SEQ_W(SEQ_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .grp_seq   (grp_seq),
            .new_seq   (new_seq),
            .prev_item (p_item),
            .prev_valid(p_valid),
            .prev_seq  (p_seq),
            .prev_match(p_match),
            .next_item (n_item),
            .next_valid(n_valid),
            .next_seq  (n_seq),
            .item      (c_item[i]),
            .valid     (c_valid[i]),
            .seq       (c_seq[i]),
            .match     (c_match[i])
        );
    end

    assign head_item    = c_item[0];
    assign head_valid   = c_valid[0];
    assign second_item  = c_item[1];
    assign second_valid = c_valid[1];
    assign full         = c_valid[DEPTH-1];

endmodule

`default_nettype wire

// ===== hdl/group_aware_queue_top.sv =====
`default_nettype none

// The result passes the command register, then the cell update and the result register,
// which load on the same edge when the result side is free.
// A new item is taken after the pending one executes, even while the previous result waits.
// The queue is a row of DEPTH cells; every operation updates all cells on the same edge.
// Reset (aresetn low, synchronous): queue empty, all groups absent, counters 0,
// service_time 2. No clearing pass is needed.
module group_aware_queue_top #(
    parameter int unsigned DEPTH  = gaq_pkg::DEPTH_DEF,
    parameter int unsigned GROUPS = gaq_pkg::GROUPS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire gaq_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output gaq_pkg::out_t                    m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gaq_pkg::SVC_W-1:0]   cfg_wr_data
);

    localparam int unsigned SEQ_W  = $clog2(DEPTH) + 1;
    localparam int unsigned GVALS  = 2 ** gaq_pkg::GROUP_W;
    localparam int unsigned NG     = (GROUPS < GVALS) ? GROUPS : GVALS;
    localparam int unsigned NG_W   = (NG > 1) ? $clog2(NG) : 1;
    localparam int unsigned TBL_N  = 2 ** NG_W;

    // group reduction table, built at elaboration
    logic [gaq_pkg::GROUP_W-1:0] grp_lut [GVALS];
    for (genvar g = 0; g < GVALS; g++) begin : g_lut
        localparam int unsigned RED = g % GROUPS;
        assign grp_lut[g] = gaq_pkg::GROUP_W'(RED);
    end

    gaq_pkg::in_t                op_reg;
    gaq_pkg::in_t                s_red;
    logic                        op_pend_reg, op_pend_next;
    logic                        m_valid_reg, m_valid_next;
    gaq_pkg::out_t               m_data_reg, m_data_next;
    logic [gaq_pkg::SVC_W-1:0]   svc_reg;
    logic [gaq_pkg::CNT_W-1:0]   entry_reg, exit_reg, exit_sum;
    logic [SEQ_W-1:0]            run_reg;
    logic                        tbl_valid_reg [TBL_N];
    logic [SEQ_W-1:0]            tbl_seq_reg   [TBL_N];

    gaq_pkg::ctrl_t              ctrl;
    gaq_pkg::item_t              head_item, second_item;
    logic                        head_valid, second_valid, full;
    logic                        s_xfer, exec, push_ok, pop_ok, last_of_group;
    logic [gaq_pkg::GROUP_W-1:0] grp_sel;
    logic [NG_W-1:0]             addr;
    logic                        present;
    logic [SEQ_W-1:0]            grp_seq, new_seq;

    assign s_ready = !op_pend_reg;
    assign s_xfer  = s_valid && s_ready;
    assign exec    = op_pend_reg && (!m_valid_reg || m_ready);

    assign push_ok = (op_reg.cmd == gaq_pkg::CMD_PUSH) && !full;
    assign pop_ok  = (op_reg.cmd == gaq_pkg::CMD_POP) && head_valid;

    // one table port: a pop looks at the front item's group, a push at its own
    assign grp_sel = (op_reg.cmd == gaq_pkg::CMD_POP) ? head_item.group : op_reg.group;
    assign addr    = NG_W'(grp_sel);
    assign present = tbl_valid_reg[addr];
    assign grp_seq = tbl_seq_reg[addr];
    assign new_seq = present ? grp_seq : run_reg;

    assign last_of_group = !(second_valid && (second_item.group == head_item.group));
    assign exit_sum      = exit_reg + gaq_pkg::CNT_W'(svc_reg);

    always_comb begin
        ctrl                = '0;
        ctrl.do_push        = exec && push_ok;
        ctrl.do_pop         = exec && pop_ok;
        ctrl.present        = present;
        ctrl.new_item.tag   = op_reg.tag;
        ctrl.new_item.group = op_reg.group;
        ctrl.new_item.entry = entry_reg;
    end

    gaq_chain #(
        .DEPTH(DEPTH),
        .SEQ_W(SEQ_W)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .grp_seq     (grp_seq),
        .new_seq     (new_seq),
        .head_item   (head_item),
        .head_valid  (head_valid),
        .second_item (second_item),
        .second_valid(second_valid),
        .full        (full)
    );

    always_comb begin
        op_pend_next = op_pend_reg;
        if (exec) begin
            op_pend_next = 1'b0;
        end
        if (s_xfer) begin
            op_pend_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exec) begin
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        s_red       = s_data;
        s_red.group = grp_lut[s_data.group];
    end

    always_comb begin
        m_data_next = '0;
        if (op_reg.cmd == gaq_pkg::CMD_PUSH) begin
            if (push_ok) begin
                m_data_next.status         = gaq_pkg::ST_PUSHED;
                m_data_next.assigned_entry = entry_reg;
            end else begin
                m_data_next.status = gaq_pkg::ST_FULL;
            end
        end else begin
            if (pop_ok) begin
                m_data_next.status       = gaq_pkg::ST_SERVED;
                m_data_next.served_tag   = head_item.tag;
                m_data_next.served_group = head_item.group;
                m_data_next.served_entry = head_item.entry;
                m_data_next.exit_time    = exit_sum;
            end else begin
                m_data_next.status = gaq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            svc_reg     <= gaq_pkg::SVC_RESET;
            entry_reg   <= '0;
            exit_reg    <= '0;
            run_reg     <= '0;
            for (int i = 0; i < TBL_N; i++) begin
                tbl_valid_reg[i] <= 1'b0;
            end
        end else begin
            op_pend_reg <= op_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                svc_reg <= cfg_wr_data;
            end
            if (ctrl.do_push) begin
                entry_reg           <= entry_reg + 1'b1;
                tbl_valid_reg[addr] <= 1'b1;
                if (!present) begin
                    run_reg <= run_reg + 1'b1;
                end
            end
            if (ctrl.do_pop) begin
                exit_reg <= exit_sum;
                if (last_of_group) begin
                    tbl_valid_reg[addr] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg <= s_red;
        end
        if (ctrl.do_push && !present) begin
            tbl_seq_reg[addr] <= run_reg;
        end
        if (exec) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
